### rtl/qte_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to Euler converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

   localparam int DATA_W                = 36;   // CORDIC vector width
   localparam int ANG_W                 = 32;   // CORDIC angle accumulator, 2^31 = pi
   localparam int OUT_ANG_W             = 16;
   localparam int LANES                 = 3;
   localparam int MAX_CORDIC_STAGES     = 24;
   localparam int DEFAULT_CORDIC_STAGES = 16;
   localparam int SQRT_STAGES           = 31;   // one root bit per stage
   localparam int REM_W                 = 61;   // radicand width
   localparam int ROOT_W                = 31;
   localparam int CSR_INDEX_W           = 8;
   localparam int CSR_DATA_W            = 16;

   localparam int LANE_HEAD  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_BANK  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 8'd1;
   localparam logic [14:0]            THRESHOLD_RESET = 15'd32764;

   typedef struct packed {
      logic lock;
      logic sp_pos;
   } tag_type;

   // operands that ride alongside the square root pipe
   typedef struct packed {
      tag_type                  tag;
      logic signed [DATA_W-1:0] h_y;
      logic signed [DATA_W-1:0] h_x;
      logic signed [DATA_W-1:0] b_y;
      logic signed [DATA_W-1:0] b_x;
      logic signed [DATA_W-1:0] p_y;
   } sq_side_type;

   typedef struct packed {
      logic [OUT_ANG_W-1:0] heading;
      logic [OUT_ANG_W-1:0] pitch;
      logic [OUT_ANG_W-1:0] bank;
      logic                 lock;
   } result_type;

   // atan(2^-i), scaled so that 2^31 = pi
   function automatic logic [ANG_W-1:0] atan_entry(input int idx);
      logic [ANG_W-1:0] v;
      case (idx)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/qte_cordic.sv
// Three-lane pipelined vectoring CORDIC: one iteration per register stage.
// Depends on qte_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic
   import qte_pkg::*;
#(
   parameter int STAGES = DEFAULT_CORDIC_STAGES
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic                               in_valid,
   input  wire logic [LANES-1:0][DATA_W-1:0]       in_y,
   input  wire logic [LANES-1:0][DATA_W-1:0]       in_x,
   input  wire tag_type                            in_tag,
   output logic                                    out_valid,
   output logic [LANES-1:0][OUT_ANG_W-1:0]         out_ang,
   output tag_type                                 out_tag
);

   logic signed [DATA_W-1:0] y_ff    [0:STAGES][0:LANES-1];
   logic signed [DATA_W-1:0] x_ff    [0:STAGES][0:LANES-1];
   logic        [ANG_W-1:0]  a_ff    [0:STAGES][0:LANES-1];
   logic                     zero_ff [0:STAGES][0:LANES-1];
   tag_type                  tag_ff  [0:STAGES];
   logic        [STAGES:0]   valid_ff;

   // stage 0: fold left half plane into the right, flag the zero vector
   for (genvar l = 0; l < LANES; l++) begin : g_prep
      logic signed [DATA_W-1:0] y_cur, x_cur;
      assign y_cur = $signed(in_y[l]);
      assign x_cur = $signed(in_x[l]);
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[0][l] <= (x_cur == '0) && (y_cur == '0);
            if (x_cur[DATA_W-1]) begin
               x_ff[0][l] <= -x_cur;
               y_ff[0][l] <= -y_cur;
               a_ff[0][l] <= {1'b1, {(ANG_W-1){1'b0}}};
            end else begin
               x_ff[0][l] <= x_cur;
               y_ff[0][l] <= y_cur;
               a_ff[0][l] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) tag_ff[0] <= in_tag;
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic [ANG_W-1:0] ATAN_I = atan_entry(i);
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic signed [DATA_W-1:0] dx, dy, x_in, y_in;
         logic        [ANG_W-1:0]  a_in;
         assign dx = y_ff[i][l] >>> i;
         assign dy = x_ff[i][l] >>> i;
         always_comb begin
            if (!y_ff[i][l][DATA_W-1]) begin
               x_in = x_ff[i][l] + dx;
               y_in = y_ff[i][l] - dy;
               a_in = a_ff[i][l] + ATAN_I;
            end else begin
               x_in = x_ff[i][l] - dx;
               y_in = y_ff[i][l] + dy;
               a_in = a_ff[i][l] - ATAN_I;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i+1][l]    <= x_in;
               y_ff[i+1][l]    <= y_in;
               a_ff[i+1][l]    <= a_in;
               zero_ff[i+1][l] <= zero_ff[i][l];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) tag_ff[i+1] <= tag_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[STAGES-1:0], in_valid};
      end
   end

   // round to 16 bits, wrap modulo one turn
   for (genvar l = 0; l < LANES; l++) begin : g_out
      logic [ANG_W-1:0] rnd;
      assign rnd        = a_ff[STAGES][l] + 32'h0000_8000;
      assign out_ang[l] = zero_ff[STAGES][l] ? '0 : rnd[ANG_W-1:ANG_W-OUT_ANG_W];
   end

   assign out_valid = valid_ff[STAGES];
   assign out_tag   = tag_ff[STAGES];

endmodule
`default_nettype wire

### rtl/quaternion_to_euler_angles.sv
// Quaternion (Q1.15) to heading, pitch and bank binary angles.
// Throughput: one request per cycle; the pipe halts as a whole only when the output
// register and its skid register are both full.
// Reset (synchronous, active high) empties the pipe and restores direction_mode = 0,
// lock_threshold = 32764.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles
   import qte_pkg::*;
#(
   parameter int CORDIC_STAGES = DEFAULT_CORDIC_STAGES   // 8 to 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [63:0]            req_tdata,
   // result: heading_angle [15:0], pitch_angle [31:16], bank_angle [47:32]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [47:0]                 rsp_tdata,
   // result flag: gimbal_lock [0]
   output logic [0:0]                  rsp_tuser,
   // register writes: 0 direction_mode, 1 lock_threshold
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam logic signed [33:0] HALF  = 34'sd536870912;   // 0.5 in Q2.30
   localparam logic signed [33:0] RBIAS = 34'sd8192;        // rounding term for -2*p
   localparam logic signed [33:0] SPMAX = 34'sd32768;

   // ---------------------------------------------------------------- registers
   logic        direction_ff;
   logic [14:0] threshold_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DIRECTION: direction_ff <= csr_data[0];
            CSR_THRESHOLD: threshold_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // Whole pipe advances together; the skid register frees the output side so
   // a stall on rsp never drops or repeats anything.
   logic skid_valid_ff;
   logic en;
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // ---------------------------------------------------------------- stage 1: products
   logic signed [15:0] qw, qx, qy, qz;
   assign qw = $signed(req_tdata[15:0]);
   assign qx = $signed(req_tdata[31:16]);
   assign qy = $signed(req_tdata[47:32]);
   assign qz = $signed(req_tdata[63:48]);

   logic               s1_valid_ff;
   logic signed [31:0] s1_wx_ff, s1_wy_ff, s1_wz_ff, s1_xx_ff, s1_yy_ff, s1_zz_ff;
   logic signed [31:0] s1_xy_ff, s1_xz_ff, s1_yz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_wx_ff <= qw * qx;
         s1_wy_ff <= qw * qy;
         s1_wz_ff <= qw * qz;
         s1_xx_ff <= qx * qx;
         s1_yy_ff <= qy * qy;
         s1_zz_ff <= qz * qz;
         s1_xy_ff <= qx * qy;
         s1_xz_ff <= qx * qz;
         s1_yz_ff <= qy * qz;
      end
   end

   // ---------------------------------------------------------------- stage 2: sums, sin(pitch)
   logic signed [33:0] wx, wy, wz, xx, yy, zz, xy, xz, yz;
   assign wx = 34'(s1_wx_ff);
   assign wy = 34'(s1_wy_ff);
   assign wz = 34'(s1_wz_ff);
   assign xx = 34'(s1_xx_ff);
   assign yy = 34'(s1_yy_ff);
   assign zz = 34'(s1_zz_ff);
   assign xy = 34'(s1_xy_ff);
   assign xz = 34'(s1_xz_ff);
   assign yz = 34'(s1_yz_ff);

   logic signed [33:0] p_sum, sp_raw;
   logic signed [16:0] sp_in;
   logic signed [33:0] lnum_in, hnum_in, bnum_in;

   always_comb begin
      p_sum  = direction_ff ? (yz + wx) : (yz - wx);
      sp_raw = (RBIAS - p_sum) >>> 14;
      if (sp_raw > SPMAX)       sp_in = 17'sd32768;
      else if (sp_raw < -SPMAX) sp_in = -17'sd32768;
      else                      sp_in = sp_raw[16:0];
      lnum_in = direction_ff ? (-xz - wy) : (wy - xz);
      hnum_in = direction_ff ? (xz - wy) : (xz + wy);
      bnum_in = direction_ff ? (xy - wz) : (xy + wz);
   end

   logic               s2_valid_ff;
   logic signed [16:0] s2_sp_ff;
   logic signed [33:0] s2_lnum_ff, s2_hnum_ff, s2_bnum_ff, s2_lx_ff, s2_hx_ff, s2_bx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sp_ff   <= sp_in;
         s2_lnum_ff <= lnum_in;
         s2_hnum_ff <= hnum_in;
         s2_bnum_ff <= bnum_in;
         s2_lx_ff   <= HALF - yy - zz;
         s2_hx_ff   <= HALF - xx - yy;
         s2_bx_ff   <= HALF - xx - zz;
      end
   end

   // ---------------------------------------------------------------- stage 3: lock test, 1 - sp^2
   logic [16:0]        sp_mag;
   logic               lock_in;
   logic signed [33:0] sp_sq;
   logic [31:0]        rem_wide;
   sq_side_type        side_in;

   always_comb begin
      sp_mag   = s2_sp_ff[16] ? 17'(-s2_sp_ff) : 17'(s2_sp_ff);
      lock_in  = sp_mag > {2'b00, threshold_ff};
      sp_sq    = s2_sp_ff * s2_sp_ff;
      rem_wide = 32'h4000_0000 - sp_sq[31:0];
      side_in.tag.lock   = lock_in;
      side_in.tag.sp_pos = !s2_sp_ff[16] && (s2_sp_ff != '0);
      side_in.h_y = lock_in ? DATA_W'(s2_lnum_ff) : DATA_W'(s2_hnum_ff);
      side_in.h_x = lock_in ? DATA_W'(s2_lx_ff)   : DATA_W'(s2_hx_ff);
      side_in.b_y = DATA_W'(s2_bnum_ff);
      side_in.b_x = DATA_W'(s2_bx_ff);
      side_in.p_y = DATA_W'(s2_sp_ff) <<< 15;
   end

   // ---------------------------------------------------------------- square root, one bit per stage
   logic [REM_W-1:0]   sq_v_ff    [0:SQRT_STAGES];
   logic [ROOT_W-1:0]  sq_r_ff    [0:SQRT_STAGES];
   sq_side_type        sq_side_ff [0:SQRT_STAGES];
   logic [SQRT_STAGES:0] sq_valid_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_v_ff[0]    <= {rem_wide[30:0], 30'd0};
         sq_r_ff[0]    <= '0;
         sq_side_ff[0] <= side_in;
      end
   end

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      localparam int K = SQRT_STAGES - 1 - j;
      logic [63:0] trial;
      logic [63:0] v_ext;
      assign trial = ({33'd0, sq_r_ff[j]} << (K + 1)) + (64'd1 << (2 * K));
      assign v_ext = {3'd0, sq_v_ff[j]};
      always_ff @(posedge clock) begin
         if (en) begin
            sq_side_ff[j+1] <= sq_side_ff[j];
            if (v_ext >= trial) begin
               sq_v_ff[j+1] <= sq_v_ff[j] - trial[REM_W-1:0];
               sq_r_ff[j+1] <= sq_r_ff[j] | (ROOT_W'(1) << K);
            end else begin
               sq_v_ff[j+1] <= sq_v_ff[j];
               sq_r_ff[j+1] <= sq_r_ff[j];
            end
         end
      end
   end

   // valid chain for the front end and root pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         sq_valid_ff <= '0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         sq_valid_ff <= {sq_valid_ff[SQRT_STAGES-1:0], s2_valid_ff};
      end
   end

   // ---------------------------------------------------------------- CORDIC lanes
   logic [LANES-1:0][DATA_W-1:0]    cd_y, cd_x;
   logic [LANES-1:0][OUT_ANG_W-1:0] cd_ang;
   logic                            cd_valid;
   tag_type                         cd_tag;

   always_comb begin
      cd_y[LANE_HEAD]  = sq_side_ff[SQRT_STAGES].h_y;
      cd_x[LANE_HEAD]  = sq_side_ff[SQRT_STAGES].h_x;
      cd_y[LANE_PITCH] = sq_side_ff[SQRT_STAGES].p_y;
      cd_x[LANE_PITCH] = DATA_W'(sq_r_ff[SQRT_STAGES]);   // cos(pitch), never negative
      cd_y[LANE_BANK]  = sq_side_ff[SQRT_STAGES].b_y;
      cd_x[LANE_BANK]  = sq_side_ff[SQRT_STAGES].b_x;
   end

   qte_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid_ff[SQRT_STAGES]),
      .in_y      (cd_y),
      .in_x      (cd_x),
      .in_tag    (sq_side_ff[SQRT_STAGES].tag),
      .out_valid (cd_valid),
      .out_ang   (cd_ang),
      .out_tag   (cd_tag)
   );

   // ---------------------------------------------------------------- result select
   result_type res;
   always_comb begin
      res.heading = cd_ang[LANE_HEAD];
      res.lock    = cd_tag.lock;
      if (cd_tag.lock) begin
         res.pitch = cd_tag.sp_pos ? 16'h4000 : 16'hC000;   // plus or minus half pi
         res.bank  = '0;
      end else begin
         res.pitch = cd_ang[LANE_PITCH];
         res.bank  = cd_ang[LANE_BANK];
      end
   end

   // ---------------------------------------------------------------- output + skid
   logic       rsp_valid_ff;
   result_type rsp_ff, skid_ff;
   logic       slot_free;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (slot_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= cd_valid;
         end
      end else if (cd_valid && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : res;
      end else if (en) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_ff.bank, rsp_ff.pitch, rsp_ff.heading};
   assign rsp_tuser[0] = rsp_ff.lock;

endmodule
`default_nettype wire

### rtl/qte_checker.sv
// Port-level checks for quaternion_to_euler_angles, attached by bind.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module qte_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_lock_bank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[47:32] == 16'h0000)
      else $error("bank not zero in gimbal lock");

   a_lock_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:16] == 16'h4000 || rsp_tdata[31:16] == 16'hC000)
      else $error("pitch not half pi in gimbal lock");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present right after reset");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
